FILE: sv/lidar_scan_obstacle_screen_macros.svh
`ifndef LIDAR_SCAN_OBSTACLE_SCREEN_MACROS_SVH
`define LIDAR_SCAN_OBSTACLE_SCREEN_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define LSO_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define LSO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lso_pkg.sv
`default_nettype none
package lso_pkg;

    localparam int FRONT_INDEX = 540;
    localparam int MAX_POINTS  = 2048;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int HIT_W       = 12;
    localparam int MM_W        = 16;
    localparam int POS_W       = 17;
    localparam int BLIND_W     = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int DIV_STEPS   = 16;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_POINTS - 1);
    localparam logic [IDX_W-1:0] IDX_FRONT = IDX_W'(FRONT_INDEX);
    localparam logic [HIT_W-1:0] HIT_MAX   = '1;

    localparam logic [MM_W-1:0]        RST_ROBOT_RADIUS = 16'd300;
    localparam logic [MM_W-1:0]        RST_MAX_DETECT   = 16'd1500;
    localparam logic [MM_W-1:0]        RST_MIN_DETECT   = 16'd400;
    localparam logic                   RST_DYN_ENABLE   = 1'b0;
    localparam logic signed [MM_W-1:0] RST_SAFETY_COEFF = 16'sd32767;
    localparam logic [MM_W-1:0]        RST_MAX_OBSTACLE = 16'd1500;
    localparam logic [BLIND_W-1:0]     RST_BLIND_HALF   = 10'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROBOT_RADIUS = 3'd0,
        REG_MAX_DETECT   = 3'd1,
        REG_MIN_DETECT   = 3'd2,
        REG_DYN_ENABLE   = 3'd3,
        REG_SAFETY_COEFF = 3'd4,
        REG_MAX_OBSTACLE = 3'd5,
        REG_BLIND_HALF   = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LEN,
        S_EVAL,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [MM_W-1:0]        robot_radius_mm;
        logic [MM_W-1:0]        max_detection_mm;
        logic [MM_W-1:0]        min_detection_mm;
        logic                   dynamic_detection_enable;
        logic signed [MM_W-1:0] speed_safety_coeff;
        logic [MM_W-1:0]        max_obstacle_mm;
        logic [BLIND_W-1:0]     blind_half_width_points;
    } lso_cfg_t;

    typedef struct packed {
        logic            start;
        logic [MM_W-1:0] dividend;
        logic [MM_W-1:0] divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [MM_W-1:0] quotient;
    } div_stat_t;

endpackage
`default_nettype wire

FILE: sv/lso_if.sv
`default_nettype none
interface lso_cfg_if;
    import lso_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [MM_W-1:0]      wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

interface lso_point_if;
    import lso_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [MM_W-1:0]         range_mm;
    logic signed [POS_W-1:0] bearing_cdeg;
    logic signed [POS_W-1:0] pos_x_mm;
    logic signed [POS_W-1:0] pos_y_mm;
    logic                    last_point;

    modport source (output valid, output range_mm, output bearing_cdeg, output pos_x_mm,
                    output pos_y_mm, output last_point, input ready);
    modport sink   (input valid, input range_mm, input bearing_cdeg, input pos_x_mm,
                    input pos_y_mm, input last_point, output ready);
endinterface

interface lso_result_if;
    import lso_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    obstacle_in_path;
    logic [HIT_W-1:0]        hit_total;
    logic [MM_W-1:0]         nearest_range_mm;
    logic signed [POS_W-1:0] nearest_bearing_cdeg;
    logic [MM_W-1:0]         avoid_weight_q16;
    logic [MM_W-1:0]         detect_length_mm;

    modport source (output valid, output obstacle_in_path, output hit_total,
                    output nearest_range_mm, output nearest_bearing_cdeg,
                    output avoid_weight_q16, output detect_length_mm, input ready);
    modport sink   (input valid, input obstacle_in_path, input hit_total,
                    input nearest_range_mm, input nearest_bearing_cdeg,
                    input avoid_weight_q16, input detect_length_mm, output ready);
endinterface
`default_nettype wire

FILE: sv/lidar_scan_obstacle_screen.sv
`default_nettype none
// Screens one lidar scan for obstacles. Points arrive one per beat on pt; each point passes
// through S_IDLE (accept), S_MUL (multiply for the speed-scaled detection length), S_LEN
// (clamp) and S_EVAL (hit test and nearest-point update), with pt.ready high only while the
// block is idle. The point flagged last_point also runs the avoidance weight through a
// restoring divider, one quotient bit per cycle for a sixteen-bit quotient, when a weight is
// due; the result is loaded into an output register in S_DONE, after S_DIV or straight after
// S_EVAL when no weight is due. A result still waiting on res holds the block until res takes
// it. The next scan may start while the loaded result waits on res. Registers on cfg must be
// written only while the block is idle, at one beat per cycle; the block does not enforce it.
`include "lidar_scan_obstacle_screen_macros.svh"
module lidar_scan_obstacle_screen (
    input  wire          clk,
    input  wire          rst_n,
    lso_cfg_if.sink      cfg,
    lso_point_if.sink    pt,
    lso_result_if.source res
);
    import lso_pkg::*;

    lso_cfg_t  cfg_q;
    div_ctrl_t div_ctrl;
    div_stat_t div_stat;

    state_t state_reg, state_next;

    logic [MM_W-1:0]         range_reg;
    logic signed [POS_W-1:0] bearing_reg;
    logic signed [POS_W-1:0] px_reg;
    logic signed [POS_W-1:0] py_reg;
    logic                    last_reg;
    logic signed [32:0]      prod_reg;
    logic [MM_W-1:0]         len_reg;
    logic [MM_W-1:0]         weight_reg;

    logic [IDX_W-1:0]        idx_reg,       idx_next;
    logic [HIT_W-1:0]        hit_reg,       hit_next;
    logic [MM_W-1:0]         best_range_reg, best_range_next;
    logic signed [POS_W-1:0] best_bear_reg,  best_bear_next;

    logic                    res_valid_reg;
    logic                    res_obstacle_reg;
    logic [HIT_W-1:0]        res_hit_reg;
    logic [MM_W-1:0]         res_range_reg;
    logic signed [POS_W-1:0] res_bear_reg;
    logic [MM_W-1:0]         res_weight_reg;
    logic [MM_W-1:0]         res_len_reg;

    logic                    accept;
    logic                    res_load;
    logic signed [16:0]      mdet_s;
    logic signed [32:0]      prod_next;
    logic [MM_W-1:0]         scaled_len;
    logic [MM_W-1:0]         len_next;
    logic signed [17:0]      rad_s;
    logic signed [17:0]      px_s;
    logic signed [17:0]      py_s;
    logic signed [17:0]      len_s;
    logic                    hit;
    logic [MM_W-1:0]         cur_best;
    logic signed [POS_W-1:0] cur_bear;
    logic [IDX_W-1:0]        blind_lo;
    logic [IDX_W-1:0]        blind_hi;
    logic                    blind;
    logic                    closer;
    logic                    weight_ok;

    lso_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    lso_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    assign mdet_s    = signed'({1'b0, cfg_q.max_detection_mm});
    assign prod_next = mdet_s * cfg_q.speed_safety_coeff;

    always_comb
    begin
        if (!cfg_q.dynamic_detection_enable)
            scaled_len = cfg_q.max_detection_mm;
        else if (prod_reg <= 0)
            scaled_len = '0;
        else
            scaled_len = prod_reg[30:15];
        len_next = (scaled_len < cfg_q.min_detection_mm) ? cfg_q.min_detection_mm : scaled_len;
    end

    assign rad_s = signed'({2'b00, cfg_q.robot_radius_mm});
    assign px_s  = {px_reg[POS_W-1], px_reg};
    assign py_s  = {py_reg[POS_W-1], py_reg};
    assign len_s = signed'({2'b00, len_reg});

    assign hit = (range_reg < cfg_q.robot_radius_mm)
              || ((px_s >= -rad_s) && (px_s < rad_s) && (py_s >= 0) && (py_s < len_s));

    assign cur_best = (idx_reg == '0) ? cfg_q.max_obstacle_mm : best_range_reg;
    assign cur_bear = (idx_reg == '0) ? '0 : best_bear_reg;

    assign blind_lo = ({1'b0, cfg_q.blind_half_width_points} <= IDX_FRONT)
                    ? (IDX_FRONT - IDX_W'(cfg_q.blind_half_width_points)) : '0;
    assign blind_hi = IDX_FRONT + IDX_W'(cfg_q.blind_half_width_points);
    assign blind    = (idx_reg >= blind_lo) && (idx_reg <= blind_hi);
    assign closer   = !blind && (range_reg < cur_best);

    assign best_range_next = closer ? range_reg   : cur_best;
    assign best_bear_next  = closer ? bearing_reg : cur_bear;
    assign weight_ok = (cfg_q.max_obstacle_mm != '0) && (best_range_next < cfg_q.max_obstacle_mm);

    assign hit_next = (hit && hit_reg != HIT_MAX) ? hit_reg + 1'b1 : hit_reg;
    assign idx_next = last_reg ? '0 : ((idx_reg < IDX_LAST) ? idx_reg + 1'b1 : idx_reg);

    always_comb
    begin
        state_next        = state_reg;
        accept            = 1'b0;
        res_load          = 1'b0;
        div_ctrl.start    = 1'b0;
        div_ctrl.dividend = cfg_q.max_obstacle_mm - best_range_next;
        div_ctrl.divisor  = cfg_q.max_obstacle_mm;
        unique case (state_reg)
            S_IDLE:
            begin
                accept = pt.valid;
                if (pt.valid)
                    state_next = S_MUL;
            end
            S_MUL:  state_next = S_LEN;
            S_LEN:  state_next = S_EVAL;
            S_EVAL:
            begin
                if (!last_reg)
                    state_next = S_IDLE;
                else if (weight_ok)
                begin
                    div_ctrl.start = 1'b1;
                    state_next     = S_DIV;
                end
                else
                    state_next = S_DONE;
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign pt.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            hit_reg        <= '0;
            best_range_reg <= RST_MAX_OBSTACLE;
            best_bear_reg  <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == S_EVAL)
            begin
                idx_reg        <= idx_next;
                hit_reg        <= hit_next;
                best_range_reg <= best_range_next;
                best_bear_reg  <= best_bear_next;
            end
            else if (res_load)
                hit_reg <= '0;

            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            range_reg   <= pt.range_mm;
            bearing_reg <= pt.bearing_cdeg;
            px_reg      <= pt.pos_x_mm;
            py_reg      <= pt.pos_y_mm;
            last_reg    <= pt.last_point;
        end
        if (state_reg == S_MUL)
            prod_reg <= prod_next;
        if (state_reg == S_LEN)
            len_reg <= len_next;
        if (state_reg == S_EVAL)
            weight_reg <= '0;
        else if (state_reg == S_DIV && div_stat.done)
            weight_reg <= div_stat.quotient;
        if (res_load)
        begin
            res_obstacle_reg <= (hit_reg >= HIT_W'(2));
            res_hit_reg      <= hit_reg;
            res_range_reg    <= best_range_reg;
            res_bear_reg     <= best_bear_reg;
            res_weight_reg   <= weight_reg;
            res_len_reg      <= len_reg;
        end
    end

    assign res.valid                = res_valid_reg;
    assign res.obstacle_in_path     = res_obstacle_reg;
    assign res.hit_total            = res_hit_reg;
    assign res.nearest_range_mm     = res_range_reg;
    assign res.nearest_bearing_cdeg = res_bear_reg;
    assign res.avoid_weight_q16     = res_weight_reg;
    assign res.detect_length_mm     = res_len_reg;

    `LSO_ASSERT(a_flag_matches_hits, res_valid_reg, res_obstacle_reg == (res_hit_reg >= HIT_W'(2)), "obstacle flag disagrees with hit total")
    `LSO_ASSERT(a_div_only_in_div, div_stat.busy, state_reg == S_DIV, "divider busy outside divide state")
    `LSO_ASSERT(a_weight_range, res_valid_reg, res_weight_reg <= 16'd32768, "avoidance weight above one half")
    `LSO_ASSERT_NEXT(a_mid_scan_returns, (state_reg == S_EVAL) && !last_reg, (state_reg == S_IDLE) && (idx_reg != '0), "mid-scan point did not return to idle with index advanced")

endmodule
`default_nettype wire

FILE: sv/lso_cfg_regs.sv
`default_nettype none
module lso_cfg_regs (
    input  wire              clk,
    input  wire              rst_n,
    lso_cfg_if.sink          cfg,
    output lso_pkg::lso_cfg_t cfg_q
);
    import lso_pkg::*;

    lso_cfg_t cfg_reg;
    lso_cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_ROBOT_RADIUS: cfg_next.robot_radius_mm          = cfg.wdata;
                REG_MAX_DETECT:   cfg_next.max_detection_mm         = cfg.wdata;
                REG_MIN_DETECT:   cfg_next.min_detection_mm         = cfg.wdata;
                REG_DYN_ENABLE:   cfg_next.dynamic_detection_enable = cfg.wdata[0];
                REG_SAFETY_COEFF: cfg_next.speed_safety_coeff       = signed'(cfg.wdata);
                REG_MAX_OBSTACLE: cfg_next.max_obstacle_mm          = cfg.wdata;
                REG_BLIND_HALF:   cfg_next.blind_half_width_points  = cfg.wdata[BLIND_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.robot_radius_mm          <= RST_ROBOT_RADIUS;
            cfg_reg.max_detection_mm         <= RST_MAX_DETECT;
            cfg_reg.min_detection_mm         <= RST_MIN_DETECT;
            cfg_reg.dynamic_detection_enable <= RST_DYN_ENABLE;
            cfg_reg.speed_safety_coeff       <= RST_SAFETY_COEFF;
            cfg_reg.max_obstacle_mm          <= RST_MAX_OBSTACLE;
            cfg_reg.blind_half_width_points  <= RST_BLIND_HALF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/lso_div.sv
`default_nettype none
module lso_div (
    input  wire                clk,
    input  wire                rst_n,
    input  lso_pkg::div_ctrl_t ctrl,
    output lso_pkg::div_stat_t stat
);
    import lso_pkg::*;

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [MM_W:0]        rem_reg,   rem_next;
    logic [MM_W-1:0]      dvs_reg,   dvs_next;
    logic [MM_W-1:0]      quo_reg,   quo_next;
    logic                 ge;
    logic [MM_W:0]        diff;

    assign ge   = rem_reg >= {1'b0, dvs_reg};
    assign diff = ge ? (rem_reg - {1'b0, dvs_reg}) : rem_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            rem_next  = {1'b0, ctrl.dividend};
            dvs_next  = ctrl.divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = {diff[MM_W-1:0], 1'b0};
            quo_next = {quo_reg[MM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import lso_pkg::*;

    localparam int CYCLE_LIMIT   = 800000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 550;

    typedef struct {
        logic [MM_W-1:0]         range_mm;
        logic signed [POS_W-1:0] bearing_cdeg;
        logic signed [POS_W-1:0] pos_x_mm;
        logic signed [POS_W-1:0] pos_y_mm;
        logic                    last_point;
    } scan_point_t;

    typedef struct {
        logic                    obstacle_in_path;
        logic [HIT_W-1:0]        hit_total;
        logic [MM_W-1:0]         nearest_range_mm;
        logic signed [POS_W-1:0] nearest_bearing_cdeg;
        logic [MM_W-1:0]         avoid_weight_q16;
        logic [MM_W-1:0]         detect_length_mm;
    } scan_report_t;

    logic clk;
    logic rst_n;

    lso_cfg_if    cfg_ch ();
    lso_point_if  pt_ch ();
    lso_result_if res_ch ();

    lidar_scan_obstacle_screen DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .pt    (pt_ch),
        .res   (res_ch)
    );

    lso_cfg_t                screen_cfg;
    logic [IDX_W-1:0]        scan_index;
    logic [HIT_W-1:0]        scan_hits;
    logic [MM_W-1:0]         nearest_range;
    logic signed [POS_W-1:0] nearest_bearing;
    scan_report_t            scan_reports_due[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;
    int rx_hold_left   = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            rx_hold_left--;
        end
        else
            res_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : report_check
        scan_report_t want;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (scan_reports_due.size() == 0)
            begin
                $error("scan report with none outstanding");
                mismatch_count++;
            end
            else
            begin
                want = scan_reports_due.pop_front();
                check_field("obstacle_in_path", want.obstacle_in_path, res_ch.obstacle_in_path);
                check_field("hit_total", want.hit_total, res_ch.hit_total);
                check_field("nearest_range_mm", want.nearest_range_mm, res_ch.nearest_range_mm);
                check_field("nearest_bearing_cdeg", want.nearest_bearing_cdeg,
                            res_ch.nearest_bearing_cdeg);
                check_field("avoid_weight_q16", want.avoid_weight_q16, res_ch.avoid_weight_q16);
                check_field("detect_length_mm", want.detect_length_mm, res_ch.detect_length_mm);
            end
        end
    end

    function automatic void clear_model();
        screen_cfg.robot_radius_mm          = RST_ROBOT_RADIUS;
        screen_cfg.max_detection_mm         = RST_MAX_DETECT;
        screen_cfg.min_detection_mm         = RST_MIN_DETECT;
        screen_cfg.dynamic_detection_enable = RST_DYN_ENABLE;
        screen_cfg.speed_safety_coeff       = RST_SAFETY_COEFF;
        screen_cfg.max_obstacle_mm          = RST_MAX_OBSTACLE;
        screen_cfg.blind_half_width_points  = RST_BLIND_HALF;
        scan_index      = '0;
        scan_hits       = '0;
        nearest_range   = RST_MAX_OBSTACLE;
        nearest_bearing = '0;
    endfunction

    function automatic void apply_register(input cfg_reg_t idx, input logic [MM_W-1:0] val);
        case (idx)
            REG_ROBOT_RADIUS: screen_cfg.robot_radius_mm          = val;
            REG_MAX_DETECT:   screen_cfg.max_detection_mm         = val;
            REG_MIN_DETECT:   screen_cfg.min_detection_mm         = val;
            REG_DYN_ENABLE:   screen_cfg.dynamic_detection_enable = val[0];
            REG_SAFETY_COEFF: screen_cfg.speed_safety_coeff       = val;
            REG_MAX_OBSTACLE: screen_cfg.max_obstacle_mm          = val;
            REG_BLIND_HALF:   screen_cfg.blind_half_width_points  = val[BLIND_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int rect_length();
        int maxd;
        int coeff;
        int prod;
        int len;
        int floor_len;
        maxd      = screen_cfg.max_detection_mm;
        floor_len = screen_cfg.min_detection_mm;
        len       = maxd;
        if (screen_cfg.dynamic_detection_enable)
        begin
            coeff = $signed(screen_cfg.speed_safety_coeff);
            prod  = maxd * coeff;
            len   = (prod <= 0) ? 0 : (prod >>> 15);
        end
        if (len < floor_len)
            len = floor_len;
        return len;
    endfunction

    function automatic bit in_blind_window(input int idx);
        int half;
        int lo;
        half = screen_cfg.blind_half_width_points;
        lo   = (half <= FRONT_INDEX) ? FRONT_INDEX - half : 0;
        return (idx >= lo) && (idx <= FRONT_INDEX + half);
    endfunction

    task automatic screen_point(input scan_point_t p);
        int           len;
        int           r;
        int           x;
        int           y;
        int           mo;
        int           nr;
        longint       w;
        bit           hit;
        scan_report_t rep;
        len = rect_length();
        r   = screen_cfg.robot_radius_mm;
        x   = p.pos_x_mm;
        y   = p.pos_y_mm;
        if (scan_index == '0)
        begin
            nearest_range   = screen_cfg.max_obstacle_mm;
            nearest_bearing = '0;
        end
        hit = (p.range_mm < screen_cfg.robot_radius_mm) ||
              (x >= -r && x < r && y >= 0 && y < len);
        if (hit && scan_hits != HIT_MAX)
            scan_hits++;
        if (!in_blind_window(scan_index) && p.range_mm < nearest_range)
        begin
            nearest_range   = p.range_mm;
            nearest_bearing = p.bearing_cdeg;
        end
        if (!p.last_point)
        begin
            if (scan_index != IDX_LAST)
                scan_index++;
        end
        else
        begin
            mo = screen_cfg.max_obstacle_mm;
            nr = nearest_range;
            w  = 0;
            if (mo != 0 && nr < mo)
                w = (longint'(mo - nr) * 32768) / mo;
            rep.obstacle_in_path     = (scan_hits >= 2);
            rep.hit_total            = scan_hits;
            rep.nearest_range_mm     = nearest_range;
            rep.nearest_bearing_cdeg = nearest_bearing;
            rep.avoid_weight_q16     = MM_W'(w);
            rep.detect_length_mm     = MM_W'(len);
            scan_reports_due.insert(scan_reports_due.size(), rep);
            scan_index = '0;
            scan_hits  = '0;
        end
    endtask

    task automatic send_point(input scan_point_t p);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            pt_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pt_ch.valid        <= 1'b1;
        pt_ch.range_mm     <= p.range_mm;
        pt_ch.bearing_cdeg <= p.bearing_cdeg;
        pt_ch.pos_x_mm     <= p.pos_x_mm;
        pt_ch.pos_y_mm     <= p.pos_y_mm;
        pt_ch.last_point   <= p.last_point;
        @(posedge clk);
        while (pt_ch.ready !== 1'b1)
            @(posedge clk);
        screen_point(p);
        @(negedge clk);
    endtask

    task automatic send_at(input int range, input int bearing, input int x, input int y,
                           input bit last);
        scan_point_t p;
        p.range_mm     = MM_W'(range);
        p.bearing_cdeg = POS_W'(bearing);
        p.pos_x_mm     = POS_W'(x);
        p.pos_y_mm     = POS_W'(y);
        p.last_point   = last;
        send_point(p);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [MM_W-1:0] val);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= val;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        apply_register(idx, val);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // drop valid, wait for every report, then let the block go quiet
    task automatic settle();
        pt_ch.valid <= 1'b0;
        @(negedge clk);
        while (scan_reports_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_pace(input int mode);
        case (mode)
            1:       begin tx_idle_pct = 81; rx_stall_pct = 0;  end
            2:       begin tx_idle_pct = 0;  rx_stall_pct = 81; end
            3:       begin tx_idle_pct = 8;  rx_stall_pct = 8;  end
            default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        endcase
    endtask

    function automatic logic signed [POS_W-1:0] clip_pos(input int v);
        if (v > 65535)
            v = 65535;
        if (v < -65535)
            v = -65535;
        return POS_W'(v);
    endfunction

    function automatic scan_point_t random_point(input int pos);
        scan_point_t p;
        int          r;
        int          len;
        int          mo;
        r   = screen_cfg.robot_radius_mm;
        len = rect_length();
        mo  = screen_cfg.max_obstacle_mm;
        if (in_blind_window((pos > MAX_POINTS - 1) ? MAX_POINTS - 1 : pos))
            p.range_mm = MM_W'($urandom_range(0, 999));
        else
            case ($urandom_range(0, 3))
                0:       p.range_mm = MM_W'($urandom_range(0, r));
                1:       p.range_mm = MM_W'($urandom_range(0, (mo > 65525) ? 65535 : mo + 10));
                default: p.range_mm = MM_W'($urandom());
            endcase
        p.bearing_cdeg = POS_W'(int'($urandom_range(0, 72000)) - 36000);
        if ($urandom_range(0, 1))
            p.pos_x_mm = clip_pos(int'($urandom_range(0, 2 * r + 4)) - r - 2);
        else
            p.pos_x_mm = clip_pos(int'($urandom_range(0, 131070)) - 65535);
        if ($urandom_range(0, 1))
            p.pos_y_mm = clip_pos(int'($urandom_range(0, len + 2)) - 1);
        else
            p.pos_y_mm = clip_pos(int'($urandom_range(0, 131070)) - 65535);
        p.last_point = 1'b0;
        return p;
    endfunction

    task automatic send_random_scan(input int n);
        scan_point_t p;
        for (int i = 0; i < n; i++)
        begin
            p            = random_point(i);
            p.last_point = (i == n - 1);
            send_point(p);
        end
    endtask

    function automatic logic [MM_W-1:0] pick_mm(input logic [MM_W-1:0] lo_end,
                                                input logic [MM_W-1:0] hi_end,
                                                input int typical);
        case ($urandom_range(0, 5))
            0:       return lo_end;
            1:       return hi_end;
            2, 3:    return MM_W'($urandom_range(0, typical));
            default: return MM_W'($urandom());
        endcase
    endfunction

    task automatic randomise_config();
        logic [MM_W-1:0] coeff;
        logic [MM_W-1:0] blind;
        case ($urandom_range(0, 4))
            0:       coeff = 16'h8000;
            1:       coeff = 16'h7FFF;
            2:       coeff = 16'h0000;
            default: coeff = MM_W'($urandom());
        endcase
        case ($urandom_range(0, 4))
            0:       blind = 16'd0;
            1:       blind = 16'd540;
            2:       blind = 16'd1023;
            default: blind = MM_W'($urandom_range(0, 1023));
        endcase
        write_reg(REG_ROBOT_RADIUS, pick_mm(16'd0, 16'hFFFF, 2000));
        write_reg(REG_MAX_DETECT, pick_mm(16'd0, 16'hFFFF, 5000));
        write_reg(REG_MIN_DETECT, pick_mm(16'd0, 16'hFFFF, 1500));
        write_reg(REG_DYN_ENABLE, MM_W'($urandom_range(0, 1)));
        write_reg(REG_SAFETY_COEFF, coeff);
        write_reg(REG_MAX_OBSTACLE, pick_mm(16'd1, 16'hFFFF, 5000));
        write_reg(REG_BLIND_HALF, blind);
    endtask

    task automatic test_reset_scans();
        set_pace(0);
        send_at(299, 36000, 5000, 5000, 1'b0);
        send_at(300, -36000, -300, 0, 1'b0);
        send_at(1000, 100, 299, 1499, 1'b0);
        send_at(1000, 200, 300, 0, 1'b0);
        send_at(1000, 300, 0, 1500, 1'b0);
        send_at(1000, 400, 0, -1, 1'b0);
        send_at(0, 0, -65535, 65535, 1'b0);
        send_at(65535, -1, 65535, -65535, 1'b1);
        send_at(2000, 500, -301, 10, 1'b1);
        send_at(500, 600, 0, 100, 1'b0);
        send_at(100, -600, 70000, 0, 1'b1);
        settle();
    endtask

    task automatic test_detect_length();
        write_reg(REG_DYN_ENABLE, 16'd1);
        write_reg(REG_SAFETY_COEFF, 16'h8000);
        send_at(5000, 10, 0, 399, 1'b0);
        send_at(5000, 20, 0, 400, 1'b0);
        send_at(5000, 30, -1, 0, 1'b1);
        settle();
        write_reg(REG_MAX_DETECT, 16'hFFFF);
        write_reg(REG_SAFETY_COEFF, 16'h7FFF);
        write_reg(REG_MIN_DETECT, 16'd0);
        send_at(5000, 40, 0, 65532, 1'b0);
        send_at(5000, 50, 0, 65533, 1'b1);
        settle();
    endtask

    task automatic test_obstacle_cutoff();
        write_reg(REG_MAX_OBSTACLE, 16'd0);
        send_at(0, 1234, 0, 0, 1'b1);
        settle();
        write_reg(REG_MAX_OBSTACLE, 16'd2000);
        send_at(1800, 111, 9000, 9000, 1'b0);
        send_at(1900, 222, 9000, 9000, 1'b0);
        settle();
        write_reg(REG_MAX_OBSTACLE, 16'd1000);
        send_at(1950, 333, 9000, 9000, 1'b1);
        settle();
    endtask

    task automatic test_blind_window();
        set_pace(0);
        write_reg(REG_MAX_OBSTACLE, 16'hFFFF);
        write_reg(REG_BLIND_HALF, 16'd20);
        send_random_scan(580);
        settle();
        write_reg(REG_BLIND_HALF, 16'd540);
        send_random_scan(30);
        settle();
        write_reg(REG_BLIND_HALF, 16'd700);
        send_random_scan(30);
        settle();
    endtask

    task automatic test_hit_run();
        set_pace(0);
        write_reg(REG_ROBOT_RADIUS, 16'hFFFF);
        write_reg(REG_BLIND_HALF, 16'd1023);
        send_random_scan(150);
        send_random_scan(5);
        settle();
    endtask

    task automatic test_output_backpressure();
        set_pace(0);
        randomise_config();
        @(posedge clk);
        rx_hold_left = 600;
        @(negedge clk);
        repeat (8) send_random_scan(3);
        settle();
    endtask

    task automatic test_random_scans();
        int sent;
        int phase;
        int n;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS || phase < 4)
        begin
            settle();
            set_pace(phase % 4);
            randomise_config();
            repeat (8)
            begin
                n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
                send_random_scan(n);
                sent += n;
            end
            phase++;
        end
        settle();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.reg_index   = '0;
        cfg_ch.wdata       = '0;
        pt_ch.valid        = 1'b0;
        pt_ch.range_mm     = '0;
        pt_ch.bearing_cdeg = '0;
        pt_ch.pos_x_mm     = '0;
        pt_ch.pos_y_mm     = '0;
        pt_ch.last_point   = 1'b0;
        clear_model();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_scans();
        test_detect_length();
        test_obstacle_cutoff();
        test_blind_window();
        test_hit_run();
        test_output_backpressure();
        test_random_scans();

        settle();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
